// ----- src/cwas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cwas_pkg;

    localparam int HOURS_DEFAULT = 24;

    localparam int OP_W    = 2;
    localparam int HOUR_W  = 5;
    localparam int PRICE_W = 16;
    localparam int POWER_W = 16;
    localparam int MASK_W  = 24;
    localparam int COST_W  = 37;
    localparam int TOTAL_W = 48;
    localparam int SUM_W   = 32;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHED  = 2'd1;
    localparam logic [OP_W-1:0] OP_NEWDAY = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic KIND_FIXED = 1'b0;
    localparam logic KIND_SHIFT = 1'b1;

    localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [HOUR_W-1:0]  hour;
        logic [PRICE_W-1:0] hour_price;
        logic               kind;
        logic [HOUR_W-1:0]  hours_needed;
        logic [HOUR_W-1:0]  earliest;
        logic [HOUR_W-1:0]  deadline;
        logic [POWER_W-1:0] power_per_hour;
    } in_t;

    typedef struct packed {
        logic [HOUR_W-1:0]  chosen_start;
        logic [HOUR_W-1:0]  end_hour;
        logic [MASK_W-1:0]  hour_mask;
        logic [COST_W-1:0]  window_cost;
        logic [HOUR_W-1:0]  delay;
        logic [TOTAL_W-1:0] running_total;
        logic               over_budget;
        logic               status;
    } out_t;

endpackage

`default_nettype wire

// ----- src/cheapest_window_appliance_scheduler.sv -----
// Cheapest-window appliance scheduler.
// Input channel (s_valid/s_ready/s_data): one beat per request. operation selects
// a price load for one hour (loaded in ascending hour order), a schedule request,
// or the start of a new day that clears the running total.
// Result channel (m_valid/m_ready/m_data): exactly one beat per request, in order.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes the day budget;
// always ready. The user must write it only while no request is in flight; the
// block itself does not enforce this. A price load reads the previous prefix
// sum, writes the new one and registers the result. New day, unknown operations
// and rejected requests go straight to the output state. A schedule request
// with N candidate windows (N = 1 for a fixed appliance, deadline - earliest -
// hours_needed + 2 for a shiftable one) first scans them: the window scan reads
// two prefix entries per cycle from the dual-read prefix memory and one
// subtract/compare unit checks one window per cycle; a multiply state and a
// saturating accumulate state follow. s_ready is high only while the sequencer
// is idle; the finished result sits in the output register, so the next
// request is accepted while m_ready is low and its own result waits until
// that register frees up. Reset clears the sequencer, the day total, the budget
// and the output valid. Price entries are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module cheapest_window_appliance_scheduler #(
    parameter int HOURS = cwas_pkg::HOURS_DEFAULT
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire cwas_pkg::in_t                s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output cwas_pkg::out_t                    m_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [cwas_pkg::TOTAL_W-1:0]       cfg_data
);

    localparam int AW = (HOURS > 1) ? $clog2(HOURS) : 1;
    localparam int PW = cwas_pkg::PRICE_W + $clog2(HOURS + 1);
    localparam int XW = cwas_pkg::HOUR_W + 1;
    localparam int SW = 7;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LD_RD = 3'd1;
    localparam logic [2:0] ST_LD_WR = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    // request fields
    logic                            kind_reg;
    logic [XW-1:0]                   req_reg, start_reg, last_reg, hour_reg;
    logic [cwas_pkg::PRICE_W-1:0]    price_reg;
    logic [cwas_pkg::POWER_W-1:0]    power_reg;
    logic                            sched_reg, sched_next;
    logic                            status_reg, status_next;

    // scan pipeline
    logic [XW-1:0]                   iss_a_reg, iss_a_next;
    logic [XW-1:0]                   cmp_a_reg, cmp_a_next;
    logic                            pend_reg, pend_next;
    logic                            have_best_reg, have_best_next;
    logic [XW-1:0]                   best_reg, best_next;
    logic [cwas_pkg::SUM_W-1:0]      best_sum_reg, best_sum_next;

    // prefix memory and its ports
    logic [PW-1:0]                   prefix_mem [HOURS];
    logic [PW-1:0]                   rd_lo_reg, rd_hi_reg;
    logic                            lo_zero_reg;
    logic                            rd_en;
    logic [XW-1:0]                   rd_lo_hour, rd_hi_hour;
    logic                            wr_en;
    logic [PW-1:0]                   wr_data;

    // arithmetic
    logic [cwas_pkg::TOTAL_W-1:0]    cost_reg, cost_next;
    logic [cwas_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [cwas_pkg::TOTAL_W-1:0]    budget_reg;
    logic [cwas_pkg::SUM_W-1:0]      win_sum;
    logic [cwas_pkg::TOTAL_W:0]      total_sum;
    logic [cwas_pkg::COST_W-1:0]     cost_sat;

    // result assembly
    cwas_pkg::out_t                  out_reg, out_next, res;
    logic                            m_valid_reg, m_valid_next;
    logic [HOURS-1:0]                run_ones, mask_wide;
    logic [XW-1:0]                   end_x, delay_x;

    // request checks at the input
    logic                            in_acc;
    logic [XW-1:0]                   in_req, in_s, in_e, in_hour, in_endx;
    logic                            in_span_bad, in_hour_bad;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign in_acc    = s_valid && s_ready;

    assign in_req  = {1'b0, s_data.hours_needed};
    assign in_s    = {1'b0, s_data.earliest};
    assign in_e    = {1'b0, s_data.deadline};
    assign in_hour = {1'b0, s_data.hour};
    assign in_endx = in_s + in_req - XW'(1);

    assign in_hour_bad = (in_hour == '0) || (SW'(in_hour) > SW'(HOURS));
    assign in_span_bad = (in_req == '0) || (in_s == '0) || (SW'(in_e) > SW'(HOURS))
                      || (in_endx > in_e);

    // sum of one window from two prefix entries
    assign win_sum = cwas_pkg::SUM_W'(rd_hi_reg)
                   - (lo_zero_reg ? '0 : cwas_pkg::SUM_W'(rd_lo_reg));

    // saturate cost and day total
    assign cost_sat  = (cost_reg > cwas_pkg::TOTAL_W'(cwas_pkg::COST_MAX))
                     ? cwas_pkg::COST_MAX : cost_reg[cwas_pkg::COST_W-1:0];
    assign total_sum = {1'b0, total_reg} + (cwas_pkg::TOTAL_W + 1)'(cost_sat);

    // build the result beat
    assign end_x     = best_reg + req_reg - XW'(1);
    assign delay_x   = best_reg - start_reg;
    assign run_ones  = {HOURS{1'b1}} >> (SW'(HOURS) - SW'(req_reg));
    assign mask_wide = run_ones << (best_reg - XW'(1));

    always_comb begin
        res               = '0;
        res.running_total = total_reg;
        res.over_budget   = (total_reg > budget_reg);
        res.status        = status_reg;
        if (sched_reg) begin
            res.chosen_start = best_reg[cwas_pkg::HOUR_W-1:0];
            res.end_hour     = end_x[cwas_pkg::HOUR_W-1:0];
            res.hour_mask    = cwas_pkg::MASK_W'(mask_wide);
            res.window_cost  = cost_reg[cwas_pkg::COST_W-1:0];
            res.delay        = delay_x[cwas_pkg::HOUR_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        sched_next     = sched_reg;
        status_next    = status_reg;
        iss_a_next     = iss_a_reg;
        cmp_a_next     = cmp_a_reg;
        pend_next      = 1'b0;
        have_best_next = have_best_reg;
        best_next      = best_reg;
        best_sum_next  = best_sum_reg;
        cost_next      = cost_reg;
        total_next     = total_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        rd_en          = 1'b0;
        rd_lo_hour     = hour_reg - XW'(1);
        rd_hi_hour     = hour_reg;
        wr_en          = 1'b0;
        wr_data        = (lo_zero_reg ? '0 : rd_lo_reg) + PW'(price_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    sched_next     = 1'b0;
                    status_next    = 1'b0;
                    have_best_next = 1'b0;
                    iss_a_next     = in_s;
                    state_next     = ST_OUT;
                    case (s_data.operation)
                        cwas_pkg::OP_LOAD: begin
                            status_next = in_hour_bad;
                            if (!in_hour_bad) begin
                                state_next = ST_LD_RD;
                            end
                        end
                        cwas_pkg::OP_SCHED: begin
                            status_next = in_span_bad;
                            if (!in_span_bad) begin
                                sched_next = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                        cwas_pkg::OP_NEWDAY: begin
                            total_next = '0;
                        end
                        default: begin
                            status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_LD_RD: begin
                // fetch the prefix sum of the hour before
                rd_en      = 1'b1;
                state_next = ST_LD_WR;
            end
            ST_LD_WR: begin
                wr_en      = 1'b1;
                state_next = ST_OUT;
            end
            ST_SCAN: begin
                // issue reads for the next window start
                if (iss_a_reg <= last_reg) begin
                    rd_en      = 1'b1;
                    rd_lo_hour = iss_a_reg - XW'(1);
                    rd_hi_hour = iss_a_reg + req_reg - XW'(1);
                    pend_next  = 1'b1;
                    cmp_a_next = iss_a_reg;
                    iss_a_next = iss_a_reg + XW'(1);
                end
                // keep the earliest lowest window
                if (pend_reg) begin
                    have_best_next = 1'b1;
                    if (!have_best_reg || (win_sum < best_sum_reg)) begin
                        best_next     = cmp_a_reg;
                        best_sum_next = win_sum;
                    end
                end else if (iss_a_reg > last_reg) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cost_next  = cwas_pkg::TOTAL_W'(power_reg)
                           * cwas_pkg::TOTAL_W'(best_sum_reg);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cost_next  = cwas_pkg::TOTAL_W'(cost_sat);
                total_next = total_sum[cwas_pkg::TOTAL_W] ? cwas_pkg::TOTAL_MAX
                                                          : total_sum[cwas_pkg::TOTAL_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    out_next     = res;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            total_reg     <= '0;
            budget_reg    <= '0;
            pend_reg      <= 1'b0;
            have_best_reg <= 1'b0;
            sched_reg     <= 1'b0;
            status_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            have_best_reg <= have_best_next;
            sched_reg     <= sched_next;
            status_reg    <= status_next;
            if (cfg_valid && cfg_ready) begin
                budget_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            kind_reg  <= s_data.kind;
            req_reg   <= in_req;
            start_reg <= in_s;
            last_reg  <= (s_data.kind == cwas_pkg::KIND_SHIFT)
                       ? (in_e + XW'(1) - in_req) : in_s;
            hour_reg  <= in_hour;
            price_reg <= s_data.hour_price;
            power_reg <= s_data.power_per_hour;
        end
        iss_a_reg    <= iss_a_next;
        cmp_a_reg    <= cmp_a_next;
        best_reg     <= best_next;
        best_sum_reg <= best_sum_next;
        cost_reg     <= cost_next;
        out_reg      <= out_next;
    end

    // prefix memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prefix_mem[AW'(hour_reg - XW'(1))] <= wr_data;
        end
        if (rd_en) begin
            rd_lo_reg   <= prefix_mem[AW'(rd_lo_hour - XW'(1))];
            rd_hi_reg   <= prefix_mem[AW'(rd_hi_hour - XW'(1))];
            lo_zero_reg <= (rd_lo_hour == '0);
        end
    end

    // best window stays inside the allowed starts
    a_best_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        have_best_reg |-> (best_reg >= start_reg) && (best_reg <= last_reg))
        else $error("best window start outside allowed span");

    // a fixed appliance never moves
    a_fixed_no_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) && (kind_reg == cwas_pkg::KIND_FIXED) |-> best_reg == start_reg)
        else $error("fixed appliance moved from its earliest start");

    // rejected beats carry no window
    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> (m_data.hour_mask == '0) && (m_data.window_cost == '0))
        else $error("rejected result carries a window");

    // the day total already holds this window's cost
    a_total_covers_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.running_total >= cwas_pkg::TOTAL_W'(m_data.window_cost))
        else $error("running total below window cost");

    // nothing is presented right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
